/* sv/whb_pkg.sv */
// ----------------------------------------------------------------------------
// whb_pkg: shared types and constants for the word hash bucket block
// Hash width, register indexes, queue sizing and the per-byte mix function.
// ----------------------------------------------------------------------------
package whb_pkg;

  localparam int unsigned HASH_W    = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BUCKET_W  = 31;
  localparam int unsigned SEED_W    = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b1;

  localparam logic [BUCKET_W-1:0] TABLE_SIZE_RST = 31'd65521;

  localparam int unsigned SHL_AMT = 5;
  localparam int unsigned SHR_AMT = 2;

  // words waiting between the hash front and the modulo back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // divider step counter: one quotient bit per cycle
  localparam int unsigned DIV_CNT_W = $clog2(BUCKET_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(BUCKET_W - 1);

  typedef logic [HASH_W-1:0]   hash_t;
  typedef logic [BUCKET_W-1:0] bucket_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } back_state_e;

  // h ^ ((h << 5) + b + (h >> 2)), wrapping at 64 bits
  function automatic hash_t mix_byte(hash_t h, logic [BYTE_W-1:0] b);
    hash_t sum;
    sum = (h << SHL_AMT) + {{(HASH_W-BYTE_W){1'b0}}, b} + (h >> SHR_AMT);
    return h ^ sum;
  endfunction

endpackage

/* sv/whb_front.sv */
// ----------------------------------------------------------------------------
// whb_front: running hash update
// Mixes one byte per cycle into the running hash while the word queue is not
// full, and pushes the low 31 bits of a finished word into the word queue.
// ----------------------------------------------------------------------------
module whb_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [whb_pkg::SEED_W-1:0] seed_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [whb_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       last_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output whb_pkg::bucket_t           q_data_o
);
  import whb_pkg::*;

  hash_t hash_q, hash_d;
  logic  open_q, open_d;
  hash_t hash_cur;
  hash_t hash_new;
  logic  accept;

  // a new word starts from the seed as it stands at its first byte
  assign hash_cur   = open_q ? hash_q : {{(HASH_W-SEED_W){1'b0}}, seed_i};
  assign hash_new   = mix_byte(hash_cur, data_byte_i);
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && last_i;
  assign q_data_o   = hash_new[BUCKET_W-1:0];

  always_comb begin
    hash_d = hash_q;
    open_d = open_q;
    if (accept) begin
      hash_d = hash_new;
      open_d = !last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
  end

endmodule

/* sv/whb_queue.sv */
// ----------------------------------------------------------------------------
// whb_queue: word queue
// Short FIFO of finished word hashes between the hash front and the back.
// ----------------------------------------------------------------------------
module whb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  whb_pkg::bucket_t push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output whb_pkg::bucket_t pop_data_o
);
  import whb_pkg::*;

  bucket_t           entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/whb_back.sv */
// ----------------------------------------------------------------------------
// whb_back: bucket modulo unit
// Restoring divider, one remainder bit per cycle, with an output register
// that holds the bucket until the receiver takes it.
// ----------------------------------------------------------------------------
module whb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  whb_pkg::bucket_t table_size_i,
  input  logic             q_valid_i,
  input  whb_pkg::bucket_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output whb_pkg::bucket_t bucket_o
);
  import whb_pkg::*;

  back_state_e          state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  bucket_t              num_q, num_d;
  bucket_t              rem_q, rem_d;
  bucket_t              div_q, div_d;
  bucket_t              bucket_q, bucket_d;
  logic [BUCKET_W:0]    rem_shift;
  logic [BUCKET_W:0]    rem_sub;
  bucket_t              rem_next;

  assign rem_shift = {rem_q, num_q[BUCKET_W-1]};
  assign rem_sub   = rem_shift - {1'b0, div_q};
  assign rem_next  = (rem_shift >= {1'b0, div_q}) ? rem_sub[BUCKET_W-1:0]
                                                  : rem_shift[BUCKET_W-1:0];
  assign bucket_o  = bucket_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    rem_d       = rem_q;
    div_d       = div_q;
    bucket_d    = bucket_q;
    q_pop_o     = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          num_d   = q_data_i;
          rem_d   = '0;
          div_d   = table_size_i;
          cnt_d   = '0;
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        rem_d = rem_next;
        num_d = num_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          // a zero table size yields bucket zero
          bucket_d = (div_q == '0) ? '0 : rem_next;
          state_d  = BK_HOLD;
        end
      end
      BK_HOLD: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
    bucket_q <= bucket_d;
  end

endmodule

/* sv/word_hash_bucket.sv */
// ----------------------------------------------------------------------------
// word_hash_bucket: bucket index of a byte string
// Running 64-bit shift-add-xor hash per word, reduced to a bucket index.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one byte per request, with
// last_i marking the final byte of a word. The hash front takes a byte every
// cycle while the two-entry word queue has room.
// Output channel (out_valid_o/out_ready_i) gives one bucket per word:
// (hash & 0x7fffffff) mod table_size, zero when table_size is zero.
// The back unit is a restoring divider, one bit per cycle: a word's bucket
// is offered after the queue pop and 31 divider steps, and the back takes
// no new word from the queue until that bucket has been taken.
// If the receiver stalls, the bucket is held and the queue fills; then
// in_ready_o drops until a bucket is taken.
// Registers: index 0 seed (used from the next word), index 1 table_size.
// Reset: seed 0, table_size 65521, no word open, queue empty. No clearing
// pass is needed.
// ----------------------------------------------------------------------------
module word_hash_bucket (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [whb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [whb_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [whb_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [whb_pkg::BUCKET_W-1:0]  bucket_o
);
  import whb_pkg::*;

  logic [SEED_W-1:0] seed_q;
  bucket_t           size_q;
  logic              q_push;
  bucket_t           q_push_data;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  bucket_t           q_pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      size_q <= TABLE_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEED:       seed_q <= cfg_data_i[SEED_W-1:0];
        CFG_TABLE_SIZE: size_q <= cfg_data_i[BUCKET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  whb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_push_data)
  );

  whb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data)
  );

  whb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .table_size_i (size_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_pop_data),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bucket_o     (bucket_o)
  );

endmodule

/* bench/word_hash_bucket_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_hash_bucket_tb: self-checking bench for the word hash bucket block
// Streams words into the byte channel and checks each bucket on the result
// channel against a cycle-free model of the running hash and final modulo.
// It covers reset defaults, a seed change inside a word, table size extremes,
// random words under several settings, and back-pressure that fills the
// block.
// ----------------------------------------------------------------------------
module word_hash_bucket_tb;
  import whb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_OFF_LEN  = 300;
  localparam int unsigned MAX_PRINTS    = 20;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_SEED;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [BYTE_W-1:0]    data_byte_i = '0;
  logic                 last_i      = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  bucket_t              bucket_o;

  word_hash_bucket u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bucket_o    (bucket_o)
  );

  // model state
  logic [SEED_W-1:0] seed_reg   = '0;
  bucket_t           size_reg   = TABLE_SIZE_RST;
  hash_t             hash_state = '0;
  bit                word_open  = 1'b0;
  bucket_t           pending_buckets[$];

  int unsigned error_cnt    = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned stall_reqs   = 0;
  bit          sender_gaps  = 1'b1;
  bucket_t     want_bucket;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[word_hash_bucket] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input bucket_t got, input bucket_t want);
    if (error_cnt < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s, got %0d expected %0d", cycle_cnt, what, got, want);
    error_cnt++;
  endtask

  // running hash step and bucket reduction for one accepted byte
  function automatic void absorb_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    hash_t h;
    h = word_open ? hash_state : hash_t'(seed_reg);
    h = h ^ ((h << SHL_AMT) + hash_t'(b) + (h >> SHR_AMT));
    if (!is_last) begin
      hash_state = h;
      word_open  = 1'b1;
    end else begin
      pending_buckets.push_back((size_reg == '0) ? bucket_t'(0) : bucket_t'(h[30:0] % size_reg));
      hash_state = hash_t'(seed_reg);
      word_open  = 1'b0;
    end
  endfunction

  function automatic int unsigned idle_len(input bit allow_zero);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SEED) begin
      seed_reg = val;
      if (!word_open) hash_state = hash_t'(val);
    end else begin
      size_reg = val[BUCKET_W-1:0];
    end
    @(posedge clk_i);
  endtask

  // offer one request; returns at the edge where it was taken, valid left high
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    int unsigned gap;
    gap = sender_gaps ? idle_len(1'b1) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_i      <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_byte(b, is_last);
  endtask

  task automatic send_word(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte(BYTE_W'($urandom()), i == len - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_buckets.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side: random ready with long hold-offs on request
  initial begin : result_sink
    int unsigned served;
    int unsigned held;
    served = 0;
    @(posedge clk_i);
    forever begin
      if (served != stall_reqs) begin
        served      = stall_reqs;
        out_ready_i <= 1'b0;
        held        = 0;
        while (held < HOLD_OFF_LEN) begin
          @(posedge clk_i);
          held++;
        end
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (idle_len(1'b0)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_buckets.size() == 0) begin
        report_mismatch("bucket with no word pending", bucket_o, '0);
      end else begin
        want_bucket = pending_buckets.pop_front();
        if (bucket_o !== want_bucket) report_mismatch("bucket", bucket_o, want_bucket);
      end
    end
  end

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b1);
    wait_drained();
  endtask

  // new seed must not disturb the open word, only the next one
  task automatic test_seed_mid_word();
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b0);
    wait_drained();
    cfg_write(CFG_SEED, 32'hdead_beef);
    send_byte(8'h3c, 1'b1);
    send_byte(8'h3c, 1'b1);
    wait_drained();
  endtask

  task automatic test_table_extremes();
    cfg_write(CFG_TABLE_SIZE, 32'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    wait_drained();
    cfg_write(CFG_TABLE_SIZE, 32'd1);
    send_byte(8'hc3, 1'b1);
    wait_drained();
    cfg_write(CFG_TABLE_SIZE, 32'd2);
    cfg_write(CFG_SEED, 32'h0000_0000);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b1);
    wait_drained();
    // bit 31 of the write data is outside the register
    cfg_write(CFG_TABLE_SIZE, 32'hffff_ffff);
    cfg_write(CFG_SEED, 32'hffff_ffff);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'haa, 1'b1);
    send_byte(8'h55, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_words();
    int          budget;
    int unsigned len;
    int unsigned r;
    logic [CFG_W-1:0] val;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        cfg_write(CFG_SEED, 32'hffff_ffff);
        cfg_write(CFG_TABLE_SIZE, 32'h7fff_ffff);
      end else if (phase == 1) begin
        cfg_write(CFG_SEED, 32'h0000_0000);
        cfg_write(CFG_TABLE_SIZE, 32'd2);
      end else begin
        cfg_write(CFG_SEED, $urandom());
        val = $urandom();
        case ($urandom_range(0, 5))
          0: val[30:0] = 31'($urandom_range(2, 100));
          1: val[30:0] = 31'd65521;
          2: val[30:0] = 31'h7fff_ffff;
          3: val[30:0] = 31'($urandom_range(0, 1));
          4: val[30:0] = 31'($urandom_range(101, 1 << 20));
          default: ;
        endcase
        cfg_write(CFG_TABLE_SIZE, val);
      end
      budget = 130;
      while (budget > 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) len = $urandom_range(1, 6);
        else if (r < 95) len = $urandom_range(7, 20);
        else len = $urandom_range(21, 64);
        send_word(len);
        budget -= len;
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
      wait_drained();
    end
  endtask

  // receiver holds off while single-byte words keep coming: queue fills
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    stall_reqs++;
    for (int i = 0; i < 40; i++) send_word(1);
    sender_gaps = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_seed_mid_word();
    test_table_extremes();
    test_random_words();
    test_backpressure();
    wait_drained();
    if (error_cnt == 0)
      $display("[word_hash_bucket] OK");
    else
      $display("[word_hash_bucket] ERROR");
    $finish;
  end

endmodule
